// ===== src/hbc_pkg.sv =====
// Shared constants, types and codes of the equal-width histogram engine.
`timescale 1ns / 1ps
`default_nettype none
package hbc_pkg;

   localparam int BINS       = 64;
   localparam int BIN_IDX_W  = $clog2(BINS);
   localparam int NB_W       = $clog2(BINS + 1);
   localparam int COUNT_W    = 32;
   localparam int SAMPLE_W   = 32;
   localparam int BINS_CFG_W = 7;
   localparam int PROD_W     = SAMPLE_W + NB_W;
   localparam int STEP_W     = $clog2(PROD_W);
   localparam int CSR_IDX_W  = 2;

   typedef logic [0:0] op_type;
   localparam op_type OP_COUNT = 1'b0;
   localparam op_type OP_READ  = 1'b1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_LOWER_BOUND = 2'd0;
   localparam csr_idx_type REG_UPPER_BOUND = 2'd1;
   localparam csr_idx_type REG_BINS_IN_USE = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] LOWER_RESET = SAMPLE_W'(0);
   localparam logic signed [SAMPLE_W-1:0] UPPER_RESET = SAMPLE_W'(255);
   localparam logic [BINS_CFG_W-1:0]      BINS_RESET  = BINS_CFG_W'(BINS);
   localparam logic [COUNT_W-1:0]         COUNT_MAX   = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_READ,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== src/hbc_ifs.sv =====
// Valid/ready channel interfaces of the histogram engine: request, response, register write.
`timescale 1ns / 1ps
`default_nettype none
interface hbc_req_if import hbc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [0:0]                 operation;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic [BIN_IDX_W-1:0]       read_bin;
   modport source (output valid, operation, sample_value, read_bin, input ready);
   modport sink   (input valid, operation, sample_value, read_bin, output ready);
endinterface

interface hbc_rsp_if import hbc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BIN_IDX_W-1:0] bin_index;
   logic [COUNT_W-1:0]   bin_count;
   logic                 rejected;
   modport source (output valid, bin_index, bin_count, rejected, input ready);
   modport sink   (input valid, bin_index, bin_count, rejected, output ready);
endinterface

interface hbc_csr_if import hbc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SAMPLE_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/histogram_binning_counter_unit.sv =====
// Top level of the equal-width histogram engine: sequencer, shared divider and counter memory.
// A count word passes check, multiply, 39 restoring divider steps, clamp, counter read,
// update and output on its way to the response; a read word skips multiply, divider, clamp.
// Throughput: one word at a time; the 39-step shared restoring divider sets the count rate.
// The next request is taken while the previous response still waits in the output register.
// Reset (synchronous, active high) clears all counters through per-bin valid bits at once,
// restores the bound and bin registers to their reset values and empties the output.
`timescale 1ns / 1ps
`default_nettype none
module histogram_binning_counter_unit import hbc_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   hbc_req_if.sink   req_port,
   hbc_rsp_if.source rsp_port,
   hbc_csr_if.sink   csr_port
);

   // Configuration registers.
   logic signed [SAMPLE_W-1:0] lower_ff, lower_in;
   logic signed [SAMPLE_W-1:0] upper_ff, upper_in;
   logic [BINS_CFG_W-1:0]      bins_cfg_ff, bins_cfg_in;

   // Sequencer and datapath registers.
   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [BIN_IDX_W-1:0]       read_bin_ff, read_bin_in;
   logic [NB_W-1:0]            nb_ff, nb_in;
   logic [SAMPLE_W-1:0]        diff_ff, diff_in;
   logic [SAMPLE_W-1:0]        range_ff, range_in;
   logic [PROD_W-1:0]          num_ff, num_in;
   logic [SAMPLE_W:0]          rem_ff, rem_in;
   logic [NB_W-1:0]            quot_ff, quot_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [BIN_IDX_W-1:0]       addr_ff, addr_in;
   logic                       reject_ff, reject_in;
   logic [COUNT_W-1:0]         result_ff, result_in;

   // Counter memory with per-bin valid bits; a bin that was never written reads as zero.
   logic [COUNT_W-1:0]         count_mem [BINS];
   logic [BINS-1:0]            bin_valid_ff;
   logic [COUNT_W-1:0]         rd_data_ff;
   logic                       rd_valid_ff;
   logic                       mem_we;
   logic [COUNT_W-1:0]         mem_wdata;

   // Output register.
   logic                       out_valid_ff, out_valid_in;
   logic [BIN_IDX_W-1:0]       out_index_ff, out_index_in;
   logic [COUNT_W-1:0]         out_count_ff, out_count_in;
   logic                       out_reject_ff, out_reject_in;

   // Combinational helpers.
   logic [NB_W-1:0]            nb_eff;
   logic signed [SAMPLE_W:0]   diff_wide;
   logic signed [SAMPLE_W:0]   range_wide;
   logic [SAMPLE_W:0]          rem_shift;
   logic                       rem_ge;
   logic [COUNT_W-1:0]         cur_count;
   logic                       req_take;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.bin_index = out_index_ff;
   assign rsp_port.bin_count = out_count_ff;
   assign rsp_port.rejected  = out_reject_ff;

   // A bin setting above the number of counters behaves as the full set.
   assign nb_eff = (bins_cfg_ff > BINS_CFG_W'(BINS)) ? NB_W'(BINS) : NB_W'(bins_cfg_ff);

   assign diff_wide  = {sample_ff[SAMPLE_W-1], sample_ff} - {lower_ff[SAMPLE_W-1], lower_ff};
   assign range_wide = {upper_ff[SAMPLE_W-1], upper_ff} - {lower_ff[SAMPLE_W-1], lower_ff};

   // One restoring divider step: the remainder stays below the range, so its low bits suffice.
   assign rem_shift = {rem_ff[SAMPLE_W-1:0], num_ff[PROD_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, range_ff});

   assign cur_count = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      bins_cfg_in = bins_cfg_ff;
      if (csr_port.valid && csr_port.ready) begin
         unique case (csr_port.index)
            REG_LOWER_BOUND: lower_in    = csr_port.data;
            REG_UPPER_BOUND: upper_in    = csr_port.data;
            REG_BINS_IN_USE: bins_cfg_in = csr_port.data[BINS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sample_in     = sample_ff;
      read_bin_in   = read_bin_ff;
      nb_in         = nb_ff;
      diff_in       = diff_ff;
      range_in      = range_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      addr_in       = addr_ff;
      reject_in     = reject_ff;
      result_in     = result_ff;
      mem_we        = 1'b0;
      mem_wdata     = cur_count;
      out_index_in  = out_index_ff;
      out_count_in  = out_count_ff;
      out_reject_in = out_reject_ff;
      out_valid_in  = out_valid_ff && !rsp_port.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in       = req_port.operation;
               sample_in   = req_port.sample_value;
               read_bin_in = req_port.read_bin;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            nb_in    = nb_eff;
            diff_in  = diff_wide[SAMPLE_W-1:0];
            range_in = range_wide[SAMPLE_W-1:0];
            if (op_ff == OP_READ) begin
               addr_in   = read_bin_ff;
               reject_in = (NB_W'(read_bin_ff) >= nb_eff);
               state_in  = (NB_W'(read_bin_ff) >= nb_eff) ? ST_DONE : ST_READ;
            end else begin
               // Bad bounds, a sample outside the closed range or no bins: nothing counted.
               reject_in = (nb_eff == '0) || (upper_ff <= lower_ff) ||
                           (sample_ff < lower_ff) || (sample_ff > upper_ff);
               state_in  = reject_in ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            num_in   = PROD_W'(nb_ff) * PROD_W'(diff_ff);
            rem_in   = '0;
            quot_in  = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The quotient never exceeds the bin count, so only its low bits are kept.
            rem_in  = rem_ge ? (rem_shift - {1'b0, range_ff}) : rem_shift;
            quot_in = {quot_ff[NB_W-2:0], rem_ge};
            num_in  = {num_ff[PROD_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // A sample equal to the upper bound lands in the last bin.
            addr_in  = (quot_ff >= nb_ff) ? BIN_IDX_W'(nb_ff - NB_W'(1))
                                          : BIN_IDX_W'(quot_ff);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (op_ff == OP_COUNT) begin
               mem_wdata = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
               mem_we    = 1'b1;
            end
            result_in = mem_wdata;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_port.ready) begin
               out_valid_in  = 1'b1;
               out_reject_in = reject_ff;
               if (reject_ff) begin
                  out_count_in = '0;
                  out_index_in = (op_ff == OP_READ) ? read_bin_ff : '0;
               end else begin
                  out_count_in = result_ff;
                  out_index_in = addr_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         lower_ff     <= LOWER_RESET;
         upper_ff     <= UPPER_RESET;
         bins_cfg_ff  <= BINS_RESET;
         bin_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         bins_cfg_ff  <= bins_cfg_in;
         if (mem_we) begin
            bin_valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sample_ff     <= sample_in;
      read_bin_ff   <= read_bin_in;
      nb_ff         <= nb_in;
      diff_ff       <= diff_in;
      range_ff      <= range_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      step_ff       <= step_in;
      addr_ff       <= addr_in;
      reject_ff     <= reject_in;
      result_ff     <= result_in;
      out_index_ff  <= out_index_in;
      out_count_ff  <= out_count_in;
      out_reject_ff <= out_reject_in;
   end

   // Counter memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[addr_ff] <= mem_wdata;
      end
      rd_data_ff  <= count_mem[addr_ff];
      rd_valid_ff <= bin_valid_ff[addr_ff];
   end

endmodule
`default_nettype wire
